FILE: sv/mbt_pkg.sv
// ----------------------------------------------------------------------------
// mbt_pkg: shared types for the multibrot membership test
// Register map, payload structs, controller states and datapath commands.
// ----------------------------------------------------------------------------
package mbt_pkg;

  localparam int MBT_MAX_DIM   = 4096;
  localparam int MBT_FRAC_BITS = 28;
  localparam int APB_ADDR_W    = 5;
  localparam int APB_DATA_W    = 32;
  localparam int ACC_W         = 67;

  typedef enum logic [2:0] {
    REG_X_START  = 3'd0,
    REG_Y_START  = 3'd1,
    REG_X_STEP   = 3'd2,
    REG_Y_STEP   = 3'd3,
    REG_MAX_ITER = 3'd4,
    REG_EXPONENT = 3'd5,
    REG_LIMIT_SQ = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [31:0] x_start;
    logic [31:0] y_start;
    logic [30:0] x_step;
    logic [30:0] y_step;
    logic [15:0] max_iter;
    logic [3:0]  exponent;
    logic [31:0] limit_sq;
  } cfg_t;

  typedef struct packed {
    logic [11:0] col;
    logic [11:0] row;
  } in_req_t;

  typedef struct packed {
    logic        in_set;
    logic [11:0] col_out;
    logic [11:0] row_out;
  } out_req_t;

  typedef enum logic [4:0] {
    S_IDLE, S_MAPX0, S_MAPX1, S_MAPY0, S_MAPY1,
    S_MAG0, S_MAG1, S_MAG2, S_MAG3,
    S_WLOAD, S_CM0, S_CM1, S_CM2, S_CM3, S_CM4, S_CM5,
    S_ADD, S_DONE
  } state_t;

  // multiplier operand pairs
  typedef enum logic [2:0] {
    M_IXS, M_IYS, M_ZRZR, M_ZIZI, M_ZRWR, M_ZIWI, M_ZRWI, M_ZIWR
  } mul_sel_t;

  typedef enum logic [2:0] {
    A_HOLD, A_LOAD, A_ADD, A_SUB, A_XSUB, A_YSUB
  } acc_op_t;

  typedef enum logic [2:0] {
    D_NONE, D_CR, D_CI, D_TR, D_WSET, D_WLOAD, D_ZADD
  } dst_t;

  typedef struct packed {
    mul_sel_t mul_sel;
    acc_op_t  acc_op;
    dst_t     dst;
    logic     capture;
    logic     load_out;
    logic     in_set;
  } cmd_t;

  typedef struct packed {
    logic escape;
  } status_t;

  // saturate a wide signed value to 32-bit signed
  function automatic logic signed [31:0] sat_acc(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    begin
      hi = ACC_W'(64'sh7FFF_FFFF);
      lo = -ACC_W'(64'sh8000_0000);
      if (v > hi) begin
        sat_acc = 32'sh7FFF_FFFF;
      end else if (v < lo) begin
        sat_acc = 32'sh8000_0000;
      end else begin
        sat_acc = v[31:0];
      end
    end
  endfunction

  // 32-bit signed add with saturation
  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [32:0] s;
    begin
      s = 33'(a) + 33'(b);
      if (s[32] != s[31]) begin
        sat_add = s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
        sat_add = s[31:0];
      end
    end
  endfunction

endpackage

FILE: sv/mbt_regs.sv
// ----------------------------------------------------------------------------
// mbt_regs: configuration register file
// APB-style write/read of the seven setup registers.
// ----------------------------------------------------------------------------
module mbt_regs
  import mbt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.x_start  <= 32'h2000_0000;
      cfg.y_start  <= 32'h2000_0000;
      cfg.x_step   <= 31'h0004_0000;
      cfg.y_step   <= 31'h0004_0000;
      cfg.max_iter <= 16'd256;
      cfg.exponent <= 4'd2;
      cfg.limit_sq <= 32'h4000_0000;
    end else if (wr_en) begin
      case (idx)
        REG_X_START:  cfg.x_start  <= pwdata;
        REG_Y_START:  cfg.y_start  <= pwdata;
        REG_X_STEP:   cfg.x_step   <= pwdata[30:0];
        REG_Y_STEP:   cfg.y_step   <= pwdata[30:0];
        REG_MAX_ITER: cfg.max_iter <= pwdata[15:0];
        REG_EXPONENT: cfg.exponent <= pwdata[3:0];
        REG_LIMIT_SQ: cfg.limit_sq <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_X_START:  prdata = cfg.x_start;
      REG_Y_START:  prdata = cfg.y_start;
      REG_X_STEP:   prdata = {1'b0, cfg.x_step};
      REG_Y_STEP:   prdata = {1'b0, cfg.y_step};
      REG_MAX_ITER: prdata = {16'd0, cfg.max_iter};
      REG_EXPONENT: prdata = {28'd0, cfg.exponent};
      REG_LIMIT_SQ: prdata = cfg.limit_sq;
      default:      prdata = '0;
    endcase
  end

endmodule

FILE: sv/mbt_dpath.sv
// ----------------------------------------------------------------------------
// mbt_dpath: fixed-point datapath
// One shared registered 33x33 multiplier, an accumulator, saturation and
// the z/w/c working registers. Driven cycle by cycle from mbt_ctrl.
// ----------------------------------------------------------------------------
module mbt_dpath
  import mbt_pkg::*;
#(
  parameter int MAX_DIM   = MBT_MAX_DIM,
  parameter int FRAC_BITS = MBT_FRAC_BITS
)
(
  input  logic     clk,
  input  cfg_t     cfg,
  input  in_req_t  in_data,
  input  cmd_t     cmd,
  output status_t  status,
  output out_req_t out_data
);

  localparam int IDX_W = $clog2(MAX_DIM);

  logic [11:0]             col_q, row_q;
  logic [31:0]             col_ext, row_ext;
  logic [IDX_W-1:0]        col_idx, row_idx;
  logic signed [32:0]      ma, mb;
  logic signed [65:0]      p;
  logic signed [ACC_W-1:0] acc, acc_sh;
  logic signed [31:0]      cr, ci, zr, zi, wr, wi, tr;
  logic signed [31:0]      acc_sat, sh_sat;

  // clamp pixel index to the image size
  assign col_ext = 32'(col_q);
  assign row_ext = 32'(row_q);
  assign col_idx = (col_ext >= 32'(MAX_DIM)) ? IDX_W'(MAX_DIM - 1) : col_ext[IDX_W-1:0];
  assign row_idx = (row_ext >= 32'(MAX_DIM)) ? IDX_W'(MAX_DIM - 1) : row_ext[IDX_W-1:0];

  always_comb begin
    case (cmd.mul_sel)
      M_IXS:   begin ma = $signed(33'(col_idx)); mb = $signed({2'b00, cfg.x_step}); end
      M_IYS:   begin ma = $signed(33'(row_idx)); mb = $signed({2'b00, cfg.y_step}); end
      M_ZRZR:  begin ma = 33'(zr); mb = 33'(zr); end
      M_ZIZI:  begin ma = 33'(zi); mb = 33'(zi); end
      M_ZRWR:  begin ma = 33'(zr); mb = 33'(wr); end
      M_ZIWI:  begin ma = 33'(zi); mb = 33'(wi); end
      M_ZRWI:  begin ma = 33'(zr); mb = 33'(wi); end
      M_ZIWR:  begin ma = 33'(zi); mb = 33'(wr); end
      default: begin ma = 33'(zr); mb = 33'(zr); end
    endcase
  end

  assign acc_sh  = acc >>> FRAC_BITS;
  assign acc_sat = sat_acc(acc);
  assign sh_sat  = sat_acc(acc_sh);

  // magnitude is non-negative; anything past 32 bits also exceeds the limit
  assign status.escape = acc_sh > $signed({35'd0, cfg.limit_sq});

  always_ff @(posedge clk) begin
    p <= ma * mb;

    case (cmd.acc_op)
      A_LOAD:  acc <= ACC_W'(p);
      A_ADD:   acc <= acc + ACC_W'(p);
      A_SUB:   acc <= acc - ACC_W'(p);
      A_XSUB:  acc <= ACC_W'($signed(cfg.x_start)) - ACC_W'(p);
      A_YSUB:  acc <= ACC_W'($signed(cfg.y_start)) - ACC_W'(p);
      default: ;
    endcase

    case (cmd.dst)
      D_CR: begin
        cr <= acc_sat;
        zr <= acc_sat;
      end
      D_CI: begin
        ci <= acc_sat;
        zi <= acc_sat;
      end
      D_TR:  tr <= sh_sat;
      D_WSET: begin
        wr <= tr;
        wi <= sh_sat;
      end
      D_WLOAD: begin
        wr <= zr;
        wi <= zi;
      end
      D_ZADD: begin
        zr <= sat_add(wr, cr);
        zi <= sat_add(wi, ci);
      end
      default: ;
    endcase

    if (cmd.capture) begin
      col_q <= in_data.col;
      row_q <= in_data.row;
    end

    if (cmd.load_out) begin
      out_data.in_set  <= cmd.in_set;
      out_data.col_out <= col_q;
      out_data.row_out <= row_q;
    end
  end

endmodule

FILE: sv/mbt_ctrl.sv
// ----------------------------------------------------------------------------
// mbt_ctrl: sequencer for the membership test
// Steps the datapath through mapping, magnitude checks and z^n + c loops,
// and owns the input and output handshakes.
// ----------------------------------------------------------------------------
module mbt_ctrl
  import mbt_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t      state, state_next;
  logic [15:0] iter;
  logic [3:0]  kcnt;
  logic        first;
  logic        member;
  logic        no_iter;
  logic        last_iter;
  logic        more_mul;

  assign no_iter   = (cfg.exponent == 4'd0) || (cfg.max_iter == 16'd0);
  assign last_iter = iter == (cfg.max_iter - 16'd1);
  assign more_mul  = (5'(kcnt) + 5'd1) < 5'(cfg.exponent);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (in_valid) state_next = S_MAPX0;
      S_MAPX0: state_next = S_MAPX1;
      S_MAPX1: state_next = S_MAPY0;
      S_MAPY0: state_next = S_MAPY1;
      S_MAPY1: state_next = S_MAG0;
      S_MAG0:  state_next = S_MAG1;
      S_MAG1:  state_next = S_MAG2;
      S_MAG2:  state_next = S_MAG3;
      S_MAG3: begin
        if (status.escape) begin
          state_next = S_DONE;
        end else if (first) begin
          state_next = no_iter ? S_DONE : S_WLOAD;
        end else begin
          state_next = last_iter ? S_DONE : S_WLOAD;
        end
      end
      S_WLOAD: state_next = (cfg.exponent == 4'd1) ? S_ADD : S_CM0;
      S_CM0:   state_next = S_CM1;
      S_CM1:   state_next = S_CM2;
      S_CM2:   state_next = S_CM3;
      S_CM3:   state_next = S_CM4;
      S_CM4:   state_next = S_CM5;
      S_CM5:   state_next = more_mul ? S_CM0 : S_ADD;
      S_ADD:   state_next = S_MAG0;
      S_DONE:  if (!out_valid || out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready     = 1'b0;
    cmd.mul_sel  = M_ZRZR;
    cmd.acc_op   = A_HOLD;
    cmd.dst      = D_NONE;
    cmd.capture  = 1'b0;
    cmd.load_out = 1'b0;
    cmd.in_set   = member;
    case (state)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      S_MAPX0: cmd.mul_sel = M_IXS;
      S_MAPX1: begin
        cmd.acc_op  = A_XSUB;
        cmd.mul_sel = M_IYS;
      end
      S_MAPY0: begin
        cmd.dst    = D_CR;
        cmd.acc_op = A_YSUB;
      end
      S_MAPY1: cmd.dst = D_CI;
      S_MAG0:  cmd.mul_sel = M_ZRZR;
      S_MAG1: begin
        cmd.mul_sel = M_ZIZI;
        cmd.acc_op  = A_LOAD;
      end
      S_MAG2:  cmd.acc_op = A_ADD;
      S_WLOAD: cmd.dst = D_WLOAD;
      S_CM0:   cmd.mul_sel = M_ZRWR;
      S_CM1: begin
        cmd.mul_sel = M_ZIWI;
        cmd.acc_op  = A_LOAD;
      end
      S_CM2: begin
        cmd.mul_sel = M_ZRWI;
        cmd.acc_op  = A_SUB;
      end
      S_CM3: begin
        cmd.mul_sel = M_ZIWR;
        cmd.dst     = D_TR;
        cmd.acc_op  = A_LOAD;
      end
      S_CM4:   cmd.acc_op = A_ADD;
      S_CM5:   cmd.dst = D_WSET;
      S_ADD:   cmd.dst = D_ZADD;
      S_DONE:  cmd.load_out = !out_valid || out_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      iter      <= '0;
      kcnt      <= '0;
      first     <= 1'b0;
      member    <= 1'b0;
    end else begin
      state <= state_next;

      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      if (state == S_IDLE && in_valid) begin
        first <= 1'b1;
      end

      if (state == S_MAG3) begin
        first <= 1'b0;
        if (status.escape) begin
          member <= 1'b0;
        end else if (first) begin
          iter   <= '0;
          member <= no_iter;
        end else begin
          iter   <= iter + 16'd1;
          member <= last_iter;
        end
      end

      if (state == S_WLOAD) begin
        kcnt <= 4'd1;
      end else if (state == S_CM5) begin
        kcnt <= kcnt + 4'd1;
      end
    end
  end

endmodule

FILE: sv/multibrot_membership_test.sv
// ----------------------------------------------------------------------------
// multibrot_membership_test: escape-time membership test for one pixel
// Maps (col,row) to c in signed fixed point, checks |c|^2, then iterates
// z = z^exponent + c from z = c until escape or max_iter iterations.
// ----------------------------------------------------------------------------
//
//  channel   handshake             payload            direction
//  -------   -------------------   ----------------   ---------
//  config    psel/penable/pready   paddr/pwdata/prdata  in/out
//  in        in_valid/in_ready     in_data (col,row)    in
//  out       out_valid/out_ready   out_data             out
//
// Requests are handled one at a time, and at most max_iter iterations
// run per request. One shared registered 33x33 multiplier does all
// products: two for mapping, two per magnitude check, four per complex
// multiply (with accumulate and saturate), exponent-1 of them per
// iteration.
// Reset: synchronous, active high; loads the register defaults and idles.
// Stalls: the result sits in an output register; a new request is taken
// as soon as the sequencer is idle, and it waits only if the previous
// result is still unclaimed when the new one is finished.
//
module multibrot_membership_test
  import mbt_pkg::*;
#(
  parameter int MAX_DIM   = MBT_MAX_DIM,
  parameter int FRAC_BITS = MBT_FRAC_BITS
)
(
  input  logic                  clk,
  input  logic                  rst,
  // configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  // pixel requests
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_req_t               in_data,
  // results
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_req_t              out_data
);

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;

  // register file: x/y start and step, max_iter, exponent, limit
  mbt_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // sequencer: one request at a time
  mbt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // arithmetic and the result register
  mbt_dpath #(
    .MAX_DIM   (MAX_DIM),
    .FRAC_BITS (FRAC_BITS)
  ) u_dpath (
    .clk      (clk),
    .cfg      (cfg),
    .in_data  (in_data),
    .cmd      (cmd),
    .status   (status),
    .out_data (out_data)
  );

endmodule

FILE: verif/mbt_pixel_checker.sv
// ----------------------------------------------------------------------------
// mbt_pixel_checker: result checker for the multibrot membership test
// Tracks register writes from the config port and checks register reads.
// Predicts in_set for every accepted pixel request and compares each result
// in order with the oldest prediction.
// ----------------------------------------------------------------------------
module mbt_pixel_checker
  import mbt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  input  logic [APB_DATA_W-1:0] prdata,
  input  logic                  pready,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  in_req_t               in_data,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  out_req_t              out_data,
  output int                    outstanding,
  output int                    mismatches
);

  localparam cfg_t CFG_AT_RESET = '{
    x_start:  32'h2000_0000,
    y_start:  32'h2000_0000,
    x_step:   31'h0004_0000,
    y_step:   31'h0004_0000,
    max_iter: 16'd256,
    exponent: 4'd2,
    limit_sq: 32'h4000_0000
  };

  cfg_t     view_cfg;
  out_req_t expected_pixels[$];

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sh0_7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (v < -66'sh0_8000_0000) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  // c = start - idx * step, index clamped to the image size
  function automatic logic signed [31:0] map_axis(input logic signed [31:0] start,
                                                  input logic [30:0]        step,
                                                  input logic [11:0]        idx);
    logic signed [65:0] pos;
    logic signed [65:0] span;
    pos  = (idx >= MBT_MAX_DIM) ? MBT_MAX_DIM - 1 : idx;
    span = pos * $signed({35'b0, step});
    return sat32(start - span);
  endfunction

  // |z|^2 above the limit; a magnitude past 32 bits also lands here
  function automatic logic beyond_limit(input logic signed [31:0] zr,
                                        input logic signed [31:0] zi,
                                        input logic [31:0]        limit);
    logic signed [65:0] re2;
    logic signed [65:0] im2;
    logic [65:0]        mag;
    re2 = zr;
    re2 = re2 * re2;
    im2 = zi;
    im2 = im2 * im2;
    mag = (re2 + im2) >> MBT_FRAC_BITS;
    return mag > {34'b0, limit};
  endfunction

  // (ar + j ai) * (br + j bi), floor shift, saturate
  function automatic void complex_mul(input  logic signed [31:0] ar,
                                      input  logic signed [31:0] ai,
                                      input  logic signed [31:0] br,
                                      input  logic signed [31:0] bi,
                                      output logic signed [31:0] rr,
                                      output logic signed [31:0] ri);
    logic signed [65:0] xr, xi, yr, yi, re, im;
    xr = ar;
    xi = ai;
    yr = br;
    yi = bi;
    re = xr * yr - xi * yi;
    im = xr * yi + xi * yr;
    rr = sat32(re >>> MBT_FRAC_BITS);
    ri = sat32(im >>> MBT_FRAC_BITS);
  endfunction

  function automatic logic point_in_set(input cfg_t cfg, input in_req_t px);
    logic signed [31:0] cr, ci, zr, zi, wr, wi;
    logic signed [65:0] sum;
    int unsigned        it;
    int unsigned        k;
    cr = map_axis(cfg.x_start, cfg.x_step, px.col);
    ci = map_axis(cfg.y_start, cfg.y_step, px.row);
    if (beyond_limit(cr, ci, cfg.limit_sq)) return 1'b0;
    if (cfg.exponent == 0) return 1'b1;
    zr = cr;
    zi = ci;
    for (it = 0; it < cfg.max_iter; it++) begin
      wr = zr;
      wi = zi;
      for (k = 1; k < cfg.exponent; k++) begin
        complex_mul(zr, zi, wr, wi, wr, wi);
      end
      sum = wr;
      sum = sum + cr;
      zr  = sat32(sum);
      sum = wi;
      sum = sum + ci;
      zi  = sat32(sum);
      if (beyond_limit(zr, zi, cfg.limit_sq)) return 1'b0;
    end
    return 1'b1;
  endfunction

  always @(posedge clk) begin : watch
    out_req_t    want;
    logic [31:0] held;
    logic        mapped;
    if (rst) begin
      view_cfg = CFG_AT_RESET;
      expected_pixels.delete();
      mismatches = 0;
    end else begin
      // register traffic
      if (psel && penable && pready) begin
        if (pwrite) begin
          case (paddr[APB_ADDR_W-1:2])
            REG_X_START:  view_cfg.x_start  = pwdata;
            REG_Y_START:  view_cfg.y_start  = pwdata;
            REG_X_STEP:   view_cfg.x_step   = pwdata[30:0];
            REG_Y_STEP:   view_cfg.y_step   = pwdata[30:0];
            REG_MAX_ITER: view_cfg.max_iter = pwdata[15:0];
            REG_EXPONENT: view_cfg.exponent = pwdata[3:0];
            REG_LIMIT_SQ: view_cfg.limit_sq = pwdata;
            default: ;
          endcase
        end else begin
          mapped = 1'b1;
          held   = '0;
          case (paddr[APB_ADDR_W-1:2])
            REG_X_START:  held = view_cfg.x_start;
            REG_Y_START:  held = view_cfg.y_start;
            REG_X_STEP:   held = {1'b0, view_cfg.x_step};
            REG_Y_STEP:   held = {1'b0, view_cfg.y_step};
            REG_MAX_ITER: held = {16'b0, view_cfg.max_iter};
            REG_EXPONENT: held = {28'b0, view_cfg.exponent};
            REG_LIMIT_SQ: held = view_cfg.limit_sq;
            default:      mapped = 1'b0;
          endcase
          if (mapped && prdata !== held) begin
            $error("prdata at %0d: expected %h, got %h", paddr, held, prdata);
            mismatches++;
          end
        end
      end

      // results
      if (out_valid && out_ready) begin
        if (expected_pixels.size() == 0) begin
          $error("result with nothing pending: col_out %0d row_out %0d",
                 out_data.col_out, out_data.row_out);
          mismatches++;
        end else begin
          want = expected_pixels.pop_front();
          if (out_data.in_set !== want.in_set) begin
            $error("in_set: expected %0b, got %0b (col %0d row %0d)",
                   want.in_set, out_data.in_set, want.col_out, want.row_out);
            mismatches++;
          end
          if (out_data.col_out !== want.col_out) begin
            $error("col_out: expected %0d, got %0d", want.col_out, out_data.col_out);
            mismatches++;
          end
          if (out_data.row_out !== want.row_out) begin
            $error("row_out: expected %0d, got %0d", want.row_out, out_data.row_out);
            mismatches++;
          end
        end
      end

      // pixel requests
      if (in_valid && in_ready) begin
        want.in_set  = point_in_set(view_cfg, in_data);
        want.col_out = in_data.col;
        want.row_out = in_data.row;
        expected_pixels.push_back(want);
      end
    end
    outstanding = expected_pixels.size();
  end

endmodule

FILE: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench: top level for the multibrot membership test
// Drives pixel requests and register writes, throttles both channels with
// random idle bursts and leaves checking to mbt_pixel_checker.
// ----------------------------------------------------------------------------
module testbench;
  import mbt_pkg::*;

  // The limit covers the slowest legal run (in-set points at 256
  // iterations, plus 800 random points capped at ~160 complex multiplies
  // each, plus stalls) with plenty of margin.
  localparam int unsigned CYCLE_LIMIT   = 5_000_000;
  localparam int unsigned UNMAPPED_REG  = 7;   // first index past the map
  localparam int unsigned RANDOM_PHASES = 8;
  localparam int unsigned PHASE_PIXELS  = 100;
  localparam int unsigned MUL_BUDGET    = 160; // max_iter * exponent cap
  localparam logic [31:0] Q_FOUR        = 32'h4000_0000; // 4.0 in Q4.28

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  in_valid;
  logic                  in_ready;
  in_req_t               in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_req_t              out_data;

  int                    outstanding;
  int                    mismatches;
  int unsigned           cycle_count = 0;

  // throttle knobs, % chance of an idle burst: per pixel in, per cycle out
  int unsigned           in_gap_pct = 0;
  int unsigned           stall_pct  = 0;
  int unsigned           stall_left = 0;

  multibrot_membership_test dut (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  mbt_pixel_checker pixel_check (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .outstanding (outstanding),
    .mismatches  (mismatches)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("multibrot_membership_test: mismatch");
      $finish;
    end
  end

  // Result side back-pressure: random bursts with ready low.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ready = 1'b0;
      stall_left--;
    end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
      out_ready  = 1'b0;
      stall_left = $urandom_range(0, 8);
    end else begin
      out_ready = 1'b1;
    end
  end

  // Config write: setup cycle, then access cycle held until pready.
  task automatic apb_write(input int unsigned index, input logic [31:0] value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = APB_ADDR_W'(index * 4);
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // Config read; the checker compares prdata against its register shadow.
  task automatic apb_read(input int unsigned index);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = APB_ADDR_W'(index * 4);
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic read_back();
    for (int unsigned i = 0; i < UNMAPPED_REG; i++) begin
      apb_read(i);
    end
  endtask

  // Whole view in one go, then read it all back.
  task automatic set_view(input logic [31:0] xs, input logic [31:0] ys,
                          input logic [30:0] dx, input logic [30:0] dy,
                          input logic [15:0] iters, input logic [3:0] pw,
                          input logic [31:0] lim);
    apb_write(REG_X_START,  xs);
    apb_write(REG_Y_START,  ys);
    apb_write(REG_X_STEP,   {1'b0, dx});
    apb_write(REG_Y_STEP,   {1'b0, dy});
    apb_write(REG_MAX_ITER, {16'b0, iters});
    apb_write(REG_EXPONENT, {28'b0, pw});
    apb_write(REG_LIMIT_SQ, lim);
    read_back();
  endtask

  // One pixel request. Valid stays up with the payload until taken; an
  // optional idle burst follows. Entered and left at a falling edge.
  task automatic send_pixel(input logic [11:0] c, input logic [11:0] r);
    in_data.col = c;
    in_data.row = r;
    in_valid    = 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    if (in_gap_pct != 0 && $urandom_range(0, 99) < in_gap_pct) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
  endtask

  // Every request yields exactly one result, so an empty scoreboard means
  // the sequencer is idle; a short pause covers the output register.
  task automatic drain();
    in_valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  initial begin
    logic [31:0] xs, ys, lim;
    logic [30:0] dx, dy;
    logic [3:0]  pw;
    logic [15:0] iters;

    rst      = 1'b1;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    in_valid = 1'b0;
    in_data  = '0;
    out_ready = 1'b0;
    repeat (10) @(negedge clk);
    rst = 1'b0;

    // reset values, then a write past the map that must change nothing
    read_back();
    apb_write(UNMAPPED_REG, 32'hFFFF_FFFF);
    read_back();

    // ---- directed ----------------------------------------------------------
    in_gap_pct = 25;
    stall_pct  = 25;

    // Reset view: c = 2 - idx/1024 on both axes, z^2 + c, radius 2.
    send_pixel(12'd0,    12'd0);     // corner c = 2+2i, outside before iterating
    send_pixel(12'd4095, 12'd4095);  // far corner, outside before iterating
    send_pixel(12'd4095, 12'd0);
    send_pixel(12'd0,    12'd4095);
    send_pixel(12'd512,  12'd512);   // c = 1.5+1.5i, outside before iterating
    send_pixel(12'd1024, 12'd512);   // c = 1+1.5i, out after one iteration
    send_pixel(12'd2560, 12'd512);   // c = -0.5+1.5i, out after one iteration
    send_pixel(12'hAAA,  12'h555);
    send_pixel(12'h555,  12'hAAA);
    drain();

    // exponent zero: only the |c|^2 test
    set_view(32'h2000_0000, 32'h2000_0000, 31'h0004_0000, 31'h0004_0000,
             16'd256, 4'd0, Q_FOUR);
    send_pixel(12'd512, 12'd512);
    send_pixel(12'd0,   12'd4095);
    drain();

    // max_iter zero with a nonzero exponent
    set_view(32'h2000_0000, 32'h2000_0000, 31'h0004_0000, 31'h0004_0000,
             16'd0, 4'd3, Q_FOUR);
    send_pixel(12'd1024, 12'd512);
    send_pixel(12'd4095, 12'd4095);
    drain();

    // exponent one (z = z + c) with the largest iteration count
    set_view(32'h2000_0000, 32'h2000_0000, 31'h0004_0000, 31'h0004_0000,
             16'hFFFF, 4'd1, Q_FOUR);
    send_pixel(12'd0,   12'd0);
    send_pixel(12'd100, 12'd20);
    send_pixel(12'd511, 12'd500);    // |c|^2 ~4.54, outside before iterating
    drain();

    // coordinate saturation on both rails, magnitude past 32 bits
    set_view(32'h8000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h0000_0000,
             16'hFFFF, 4'd15, 32'hFFFF_FFFF);
    send_pixel(12'd4095, 12'd0);
    send_pixel(12'd0,    12'd4095);
    drain();

    // zero limit; tiny negative c exercises floor rounding of products
    set_view(32'h0000_0000, 32'h0000_0000, 31'h0010_0000, 31'h0000_0001,
             16'd5, 4'd2, 32'h0000_0000);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd1, 12'd0);
    send_pixel(12'd0, 12'd4095);
    drain();

    // high power: products saturate before the escape
    set_view(32'h1800_0000, 32'h0000_0000, 31'h0004_0000, 31'h0004_0000,
             16'd4, 4'd15, 32'hFFFF_FFFF);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd0, 12'd1024);
    drain();

    // ---- random views ------------------------------------------------------
    // Most views frame the set so points really iterate; one view is wild.
    for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++) begin
      pw    = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                          : 4'($urandom_range(2, 4));
      iters = 16'($urandom_range(0, MUL_BUDGET / ((pw == 0) ? 1 : pw)));
      case ($urandom_range(0, 3))
        0, 1:    lim = Q_FOUR;
        2:       lim = $urandom;
        default: lim = 32'hFFFF_FFFF;
      endcase
      if (phase == 3) begin
        xs = $urandom;
        ys = $urandom;
        dx = 31'($urandom);
        dy = 31'($urandom);
      end else begin
        // window spans 1..4 units leftward/downward from the start point
        xs = $urandom_range(32'h0400_0000, 32'h2000_0000);
        ys = $urandom_range(32'h1000_0000, 32'h2000_0000);
        dx = 31'($urandom_range(32'h0001_0000, 32'h0004_0000));
        dy = 31'($urandom_range(32'h0001_0000, 32'h0004_0000));
      end
      set_view(xs, ys, dx, dy, iters, pw, lim);

      // throttling varies per view; the final view runs flat out
      if (phase == RANDOM_PHASES - 1 || phase % 3 == 1) begin
        in_gap_pct = 0;
        stall_pct  = 0;
      end else if (phase % 3 == 0) begin
        in_gap_pct = 20;
        stall_pct  = 20;
      end else begin
        in_gap_pct = 40;
        stall_pct  = 40;
      end

      for (int unsigned n = 0; n < PHASE_PIXELS; n++) begin
        send_pixel(12'($urandom), 12'($urandom));
      end
      drain();
    end

    repeat (20) @(negedge clk);
    if (mismatches == 0) begin
      $display("multibrot_membership_test: match");
    end else begin
      $display("multibrot_membership_test: mismatch");
    end
    $finish;
  end

endmodule
